@@ rtl/core/icl_pkg.sv @@
package icl_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam logic [15:0] LIMIT_RESET = 16'd64;
  localparam logic AUTO_RETURN_RESET = 1'b0;

  typedef enum logic [1:0] {
    OP_EMIT      = 2'd0,
    OP_ACCOUNTED = 2'd1,
    OP_RESYNC    = 2'd2,
    OP_FLUSH     = 2'd3
  } op_t;

  typedef enum logic {
    REG_INFLIGHT_LIMIT   = 1'b0,
    REG_AUTO_RETURN_MODE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t         opcode;
    logic [15:0] amount;
    logic [15:0] partner_accepted;
    logic        partner_failed;
  } item_t;

  typedef struct packed {
    logic [15:0] outstanding_now;
    logic [15:0] available_now;
    logic [15:0] low_water_available;
    logic [31:0] queued_returns;
    logic [15:0] returned_now;
    logic [31:0] returned_total;
    logic        flush_error;
  } result_t;

endpackage

@@ rtl/core/icl_in_stage.sv @@
module icl_in_stage
  import icl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  input  logic        take,
  output logic        item_valid,
  output item_t       item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ rtl/core/icl_ledger.sv @@
module icl_ledger
  import icl_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  reg_idx_t    cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        advance,
  input  item_t       item,
  output result_t     result
);

  localparam int AW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MASK = {COUNT_WIDTH{1'b1}};

  logic [15:0]            limit_r;
  logic                   auto_mode_r;
  logic [COUNT_WIDTH-1:0] outstanding_r, outstanding_nxt;
  logic [31:0]            pending_r, pending_nxt;
  logic [31:0]            total_r, total_nxt;
  logic [15:0]            mark_r, mark_nxt;

  logic [AW-1:0] lim_ext, cap, amt_ext, out_ext, n_emit, sum_emit, d_acc, out_nxt_ext;
  logic [32:0]   pend_sum;
  logic [31:0]   n_flush;
  logic [15:0]   ret_now, avail;
  logic          err;

  always_comb begin
    lim_ext     = AW'(limit_r);
    cap         = (lim_ext < AW'(CNT_MASK)) ? lim_ext : AW'(CNT_MASK);
    amt_ext     = AW'(item.amount);
    out_ext     = AW'(outstanding_r);
    n_emit      = (amt_ext < cap) ? amt_ext : cap;
    sum_emit    = out_ext + n_emit;
    d_acc       = (amt_ext < out_ext) ? amt_ext : out_ext;
    pend_sum    = {1'b0, pending_r} + 33'(d_acc);
    n_flush     = (pending_r < 32'(item.amount)) ? pending_r : 32'(item.amount);
    out_nxt_ext = out_ext;
    pending_nxt = pending_r;
    total_nxt   = total_r;
    ret_now     = '0;
    err         = 1'b0;

    case (item.opcode)
      OP_EMIT: begin
        // An outstanding count above a lowered limit also lands on the cap.
        out_nxt_ext = (sum_emit > cap) ? cap : sum_emit;
      end
      OP_ACCOUNTED: begin
        out_nxt_ext = out_ext - d_acc;
        if (!auto_mode_r) begin
          pending_nxt = pend_sum[32] ? 32'hFFFF_FFFF : pend_sum[31:0];
        end
      end
      OP_RESYNC: begin
        out_nxt_ext = n_emit;
        pending_nxt = '0;
      end
      OP_FLUSH: begin
        if (item.partner_failed && (32'(item.partner_accepted) < n_flush)) begin
          ret_now = item.partner_accepted;
          err     = 1'b1;
        end else begin
          ret_now = n_flush[15:0];
        end
        pending_nxt = pending_r - 32'(ret_now);
        total_nxt   = total_r + 32'(ret_now);
      end
      default: begin
        out_nxt_ext = out_ext;
      end
    endcase

    avail = (out_nxt_ext >= lim_ext) ? 16'd0 : 16'(lim_ext - out_nxt_ext);

    mark_nxt = mark_r;
    if ((item.opcode == OP_EMIT || item.opcode == OP_RESYNC) && avail < mark_r) begin
      mark_nxt = avail;
    end

    outstanding_nxt = COUNT_WIDTH'(out_nxt_ext);

    result.outstanding_now     = 16'(out_nxt_ext);
    result.available_now       = avail;
    result.low_water_available = mark_nxt;
    result.queued_returns      = pending_nxt;
    result.returned_now        = ret_now;
    result.returned_total      = total_nxt;
    result.flush_error         = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r       <= LIMIT_RESET;
      auto_mode_r   <= AUTO_RETURN_RESET;
      outstanding_r <= '0;
      pending_r     <= '0;
      total_r       <= '0;
      mark_r        <= 16'hFFFF;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INFLIGHT_LIMIT:   limit_r     <= cfg_wdata;
          REG_AUTO_RETURN_MODE: auto_mode_r <= cfg_wdata[0];
          default:              limit_r     <= limit_r;
        endcase
      end
      if (advance) begin
        outstanding_r <= outstanding_nxt;
        pending_r     <= pending_nxt;
        total_r       <= total_nxt;
        mark_r        <= mark_nxt;
      end
    end
  end

endmodule

@@ rtl/core/icl_out_stage.sv @@
module icl_out_stage
  import icl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  // The slot frees up in the same cycle its transfer completes.
  assign can_load   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

@@ rtl/core/inflight_credit_ledger_core.sv @@
// Credit ledger for in-flight orders. Each input transfer carries an
// operation (emit, accounted, resync, flush) and produces exactly one result
// transfer with the outstanding and available counts, the low-water mark of
// available credits, the queued returns and the returned totals after that
// operation. Items land in an input register, the ledger state is updated
// as an item moves on, and the result is held in an output register. One
// item is accepted per clock while the result side keeps up. Write the
// limit and the auto-return mode only while no items are in flight.
module inflight_credit_ledger_core
  import icl_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_amount,
  input  logic [15:0] in_partner_accepted,
  input  logic        in_partner_failed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_outstanding_now,
  output logic [15:0] out_available_now,
  output logic [15:0] out_low_water_available,
  output logic [31:0] out_queued_returns,
  output logic [15:0] out_returned_now,
  output logic [31:0] out_returned_total,
  output logic        out_flush_error
);

  item_t   in_item, item;
  logic    item_valid, can_load, advance;
  result_t result, out_result;

  assign in_item.opcode           = op_t'(in_opcode);
  assign in_item.amount           = in_amount;
  assign in_item.partner_accepted = in_partner_accepted;
  assign in_item.partner_failed   = in_partner_failed;

  assign advance = item_valid && can_load;

  icl_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  icl_ledger #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ledger (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (reg_idx_t'(cfg_index)),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  icl_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_outstanding_now     = out_result.outstanding_now;
  assign out_available_now       = out_result.available_now;
  assign out_low_water_available = out_result.low_water_available;
  assign out_queued_returns      = out_result.queued_returns;
  assign out_returned_now        = out_result.returned_now;
  assign out_returned_total      = out_result.returned_total;
  assign out_flush_error         = out_result.flush_error;

endmodule

@@ rtl/core/icl_checker.sv @@
module icl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_outstanding_now,
  input logic [15:0] out_available_now,
  input logic [15:0] out_low_water_available,
  input logic [31:0] out_queued_returns,
  input logic [15:0] out_returned_now,
  input logic [31:0] out_returned_total,
  input logic        out_flush_error
);

  logic        out_xfer;
  logic [31:0] total_r, total_nxt;
  logic [15:0] lw_r, lw_nxt;

  assign out_xfer  = out_valid && out_ready;
  assign total_nxt = out_xfer ? out_returned_total : total_r;
  assign lw_nxt    = out_xfer ? out_low_water_available : lw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      lw_r    <= 16'hFFFF;
    end else begin
      total_r <= total_nxt;
      lw_r    <= lw_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_returned_total)
      && $stable(out_queued_returns) && $stable(out_outstanding_now)
      && $stable(out_available_now) && $stable(out_flush_error))
    else $error("result changed while stalled");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Each transfer's running total must grow by exactly what that flush returned.
  a_total_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> out_returned_total == total_r + {16'd0, out_returned_now})
    else $error("returned total out of step with returned count");

  a_low_water_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> out_low_water_available <= lw_r)
    else $error("low-water mark went up");

endmodule

bind inflight_credit_ledger_core icl_checker u_icl_checker (.*);

@@ tb/tb_inflight_credit_ledger_core.sv @@
`timescale 1ns / 100ps

module tb_inflight_credit_ledger_core;
  import icl_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_REPORTS = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  reg_idx_t    cfg_index = REG_INFLIGHT_LIMIT;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [15:0] in_amount = '0;
  logic [15:0] in_partner_accepted = '0;
  logic        in_partner_failed = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_outstanding_now;
  logic [15:0] out_available_now;
  logic [15:0] out_low_water_available;
  logic [31:0] out_queued_returns;
  logic [15:0] out_returned_now;
  logic [31:0] out_returned_total;
  logic        out_flush_error;

  inflight_credit_ledger_core DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_opcode              (in_opcode),
    .in_amount              (in_amount),
    .in_partner_accepted    (in_partner_accepted),
    .in_partner_failed      (in_partner_failed),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_outstanding_now    (out_outstanding_now),
    .out_available_now      (out_available_now),
    .out_low_water_available(out_low_water_available),
    .out_queued_returns     (out_queued_returns),
    .out_returned_now       (out_returned_now),
    .out_returned_total     (out_returned_total),
    .out_flush_error        (out_flush_error)
  );

  // Ledger shadow state and configuration copy.
  logic [15:0] shadow_limit = LIMIT_RESET;
  logic        shadow_auto = AUTO_RETURN_RESET;
  logic [31:0] led_outstanding = '0;
  logic [31:0] led_pending = '0;
  logic [31:0] led_returned = '0;
  logic [15:0] led_low_water = 16'hFFFF;

  item_t   order_q[$];
  result_t expected_results[$];
  item_t   cur_item = '0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      hold_ticket = 0;
  int      hold_seen = 0;
  bit      idle_on = 1'b0;
  int      mismatches = 0;
  int      cycle_count = 0;

  function automatic logic [15:0] available_credits();
    if (led_outstanding >= {16'd0, shadow_limit}) return 16'd0;
    return shadow_limit - led_outstanding[15:0];
  endfunction

  function automatic result_t ledger_apply(item_t it);
    logic [31:0] cap, n, ret;
    logic [15:0] avail;
    result_t     r;
    r   = '0;
    ret = '0;
    // The counter width equals the limit width, so the limit is the cap.
    cap = {16'd0, shadow_limit};
    case (it.opcode)
      OP_EMIT: begin
        n = ({16'd0, it.amount} < cap) ? {16'd0, it.amount} : cap;
        if (led_outstanding > cap - n) led_outstanding = cap;
        else led_outstanding = led_outstanding + n;
      end
      OP_ACCOUNTED: begin
        n = ({16'd0, it.amount} < led_outstanding) ? {16'd0, it.amount} : led_outstanding;
        led_outstanding = led_outstanding - n;
        if (!shadow_auto) begin
          if (led_pending > 32'hFFFF_FFFF - n) led_pending = 32'hFFFF_FFFF;
          else led_pending = led_pending + n;
        end
      end
      OP_RESYNC: begin
        led_outstanding = ({16'd0, it.amount} < cap) ? {16'd0, it.amount} : cap;
        led_pending = '0;
      end
      default: begin
        n = (led_pending < {16'd0, it.amount}) ? led_pending : {16'd0, it.amount};
        if (it.partner_failed && ({16'd0, it.partner_accepted} < n)) begin
          ret = {16'd0, it.partner_accepted};
          r.flush_error = 1'b1;
        end else begin
          ret = n;
        end
        led_pending  = led_pending - ret;
        led_returned = led_returned + ret;
      end
    endcase
    avail = available_credits();
    if ((it.opcode == OP_EMIT || it.opcode == OP_RESYNC) && avail < led_low_water)
      led_low_water = avail;
    r.outstanding_now     = led_outstanding[15:0];
    r.available_now       = avail;
    r.low_water_available = led_low_water;
    r.queued_returns      = led_pending;
    r.returned_now        = ret[15:0];
    r.returned_total      = led_returned;
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Driver: offers queued items, with random gaps between transfers when idle_on is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(ledger_apply(cur_item));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idle_on && order_q.size() != 0 && $urandom_range(0, 6) == 0) begin
          gap_left = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (order_q.size() != 0) begin
          cur_item = order_q.pop_front();
          in_valid            <= 1'b1;
          in_opcode           <= cur_item.opcode;
          in_amount           <= cur_item.amount;
          in_partner_accepted <= cur_item.partner_accepted;
          in_partner_failed   <= cur_item.partner_failed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and throttles out_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result transfer with nothing expected, expected none, actual 0x%0h",
                   $time, out_outstanding_now);
        end else begin
          result_t want;
          want = expected_results.pop_front();
          check_field("outstanding_now", 32'(want.outstanding_now), 32'(out_outstanding_now));
          check_field("available_now", 32'(want.available_now), 32'(out_available_now));
          check_field("low_water_available", 32'(want.low_water_available),
                      32'(out_low_water_available));
          check_field("queued_returns", want.queued_returns, out_queued_returns);
          check_field("returned_now", 32'(want.returned_now), 32'(out_returned_now));
          check_field("returned_total", want.returned_total, out_returned_total);
          check_field("flush_error", 32'(want.flush_error), 32'(out_flush_error));
        end
      end
      if (hold_seen != hold_ticket) begin
        // Long back-pressure so the block fills and stalls its input.
        hold_seen = hold_ticket;
        stall_left = 60;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(op_t op, int amt, int acc, bit failed);
    item_t it;
    it.opcode           = op;
    it.amount           = amt[15:0];
    it.partner_accepted = acc[15:0];
    it.partner_failed   = failed;
    order_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (order_q.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INFLIGHT_LIMIT) shadow_limit = val;
    else shadow_auto = val[0];
    @(negedge clk);
  endtask

  function automatic item_t random_item();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) it.opcode = OP_EMIT;
    else if (pick < 65) it.opcode = OP_ACCOUNTED;
    else if (pick < 75) it.opcode = OP_RESYNC;
    else it.opcode = OP_FLUSH;
    case ($urandom_range(0, 3))
      0:       it.amount = 16'($urandom_range(0, 65535));
      3:       it.amount = 16'($urandom_range(0, 16));
      default: it.amount = 16'($urandom_range(0, (shadow_limit == 16'd0) ? 32'd1
                                                   : {16'd0, shadow_limit}));
    endcase
    if (it.opcode == OP_FLUSH && $urandom_range(0, 1) == 1)
      it.partner_accepted = 16'($urandom_range(0, {16'd0, it.amount}));
    else
      it.partner_accepted = 16'($urandom_range(0, 65535));
    it.partner_failed = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic run_phase(logic [15:0] lim, logic [15:0] auto_word, int count, bit idle,
                           bit hold);
    wait_drained();
    write_reg(REG_INFLIGHT_LIMIT, lim);
    write_reg(REG_AUTO_RETURN_MODE, auto_word);
    idle_on = idle;
    for (int i = 0; i < count; i++) order_q.push_back(random_item());
    if (hold) hold_ticket++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: saturation, clamping, partial and failed flushes.
    idle_on = 1'b1;
    push_item(OP_EMIT, 0, 0, 0);
    push_item(OP_EMIT, 10, 16'hFFFF, 1);
    push_item(OP_EMIT, 65535, 0, 0);
    push_item(OP_ACCOUNTED, 20, 0, 1);
    push_item(OP_ACCOUNTED, 65535, 0, 0);
    push_item(OP_FLUSH, 10, 0, 0);
    push_item(OP_FLUSH, 65535, 5, 1);
    push_item(OP_FLUSH, 65535, 65535, 1);
    push_item(OP_FLUSH, 5, 0, 1);
    push_item(OP_EMIT, 30, 0, 0);
    push_item(OP_ACCOUNTED, 30, 0, 0);
    push_item(OP_FLUSH, 0, 0, 1);
    push_item(OP_FLUSH, 40, 3, 0);
    push_item(OP_RESYNC, 65535, 0, 0);
    push_item(OP_RESYNC, 0, 0, 0);
    push_item(OP_RESYNC, 17, 0, 0);
    push_item(OP_ACCOUNTED, 0, 0, 0);
    wait_drained();

    // Widest limit with auto-return: accounting queues nothing.
    write_reg(REG_INFLIGHT_LIMIT, 16'hFFFF);
    write_reg(REG_AUTO_RETURN_MODE, 16'hFFFF);
    push_item(OP_EMIT, 65535, 0, 0);
    push_item(OP_EMIT, 1, 0, 0);
    push_item(OP_ACCOUNTED, 100, 0, 0);
    push_item(OP_FLUSH, 100, 0, 1);
    wait_drained();

    // Limit lowered below outstanding: available reads zero, emit clamps.
    write_reg(REG_INFLIGHT_LIMIT, 16'd100);
    push_item(OP_ACCOUNTED, 5, 0, 0);
    push_item(OP_EMIT, 0, 0, 0);
    wait_drained();
    write_reg(REG_INFLIGHT_LIMIT, 16'd0);
    write_reg(REG_AUTO_RETURN_MODE, 16'hFFFE);
    push_item(OP_RESYNC, 9, 0, 0);
    push_item(OP_EMIT, 5, 0, 0);
    push_item(OP_ACCOUNTED, 3, 0, 0);

    run_phase(16'($urandom_range(1, 2000)), 16'd0, 200, 1'b1, 1'b1);
    run_phase(16'hFFFF, 16'd1, 150, 1'b1, 1'b0);
    run_phase(16'd0, 16'd0, 60, 1'b0, 1'b0);
    run_phase(16'd1, 16'd0, 80, 1'b1, 1'b1);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 200, 1'b1, 1'b0);
    run_phase(16'd500, 16'd0, 160, 1'b0, 1'b0);

    // Close with a short back-to-back stretch of queued returns and flushes.
    wait_drained();
    write_reg(REG_INFLIGHT_LIMIT, 16'hFFFF);
    write_reg(REG_AUTO_RETURN_MODE, 16'd0);
    idle_on = 1'b0;
    push_item(OP_RESYNC, 0, 0, 0);
    push_item(OP_EMIT, 65535, 0, 0);
    push_item(OP_ACCOUNTED, 65535, 0, 0);
    push_item(OP_FLUSH, 65535, 1234, 1);
    push_item(OP_FLUSH, 65535, 0, 0);
    push_item(OP_EMIT, 7, 0, 0);
    push_item(OP_ACCOUNTED, 7, 0, 0);
    push_item(OP_FLUSH, 7, 0, 0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
